### hdl/twvg_pkg.sv
// Shared constants and register index codes for the triangle wave value generator.
`default_nettype none

package twvg_pkg;

  // Fixed field widths of the time and period words.
  localparam int NOW_WIDTH       = 32;
  localparam int PERIOD_WIDTH    = 32;
  localparam int HALF_WIDTH      = PERIOD_WIDTH - 1;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 32'd120000;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_PERIOD = 3'd0,
    REG_PHASE  = 3'd1,
    REG_MIN    = 3'd2,
    REG_MAX    = 3'd3,
    REG_OFFSET = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

### hdl/twvg_cfg.sv
// Configuration registers and the per-cycle values derived from them.
`default_nettype none

module twvg_cfg
  import twvg_pkg::*;
#(
  parameter int VALUE_WIDTH = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]    cfg_data,
  output logic      [PERIOD_WIDTH-1:0]      period,
  output logic      [NOW_WIDTH-1:0]         phase,
  output logic      [HALF_WIDTH-1:0]        half,
  output logic                              half_zero,
  output logic      [VALUE_WIDTH-1:0]       span_mag,
  output logic                              span_neg,
  output logic      [VALUE_WIDTH+1:0]       base
);

  logic [VALUE_WIDTH-1:0] min_value;
  logic [VALUE_WIDTH-1:0] max_value;
  logic [VALUE_WIDTH-1:0] value_offset;
  logic [VALUE_WIDTH:0]   span;
  logic [VALUE_WIDTH:0]   span_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      period       <= PERIOD_RESET;
      phase        <= '0;
      min_value    <= '0;
      max_value    <= '0;
      value_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PERIOD: period       <= cfg_data[PERIOD_WIDTH-1:0];
        REG_PHASE:  phase        <= cfg_data[NOW_WIDTH-1:0];
        REG_MIN:    min_value    <= cfg_data[VALUE_WIDTH-1:0];
        REG_MAX:    max_value    <= cfg_data[VALUE_WIDTH-1:0];
        REG_OFFSET: value_offset <= cfg_data[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign span     = {max_value[VALUE_WIDTH-1], max_value} - {min_value[VALUE_WIDTH-1], min_value};
  assign span_inv = ~span + 1'b1;

  // The derived values are updated in the cycle after the registers change, long
  // before an item needs them at the multiplier.
  always_ff @(posedge clk) begin
    half      <= period[PERIOD_WIDTH-1:1];
    half_zero <= (period[PERIOD_WIDTH-1:1] == '0);
    span_neg  <= span[VALUE_WIDTH];
    span_mag  <= span[VALUE_WIDTH] ? span_inv[VALUE_WIDTH-1:0] : span[VALUE_WIDTH-1:0];
    base      <= {{2{value_offset[VALUE_WIDTH-1]}}, value_offset}
               + {{2{min_value[VALUE_WIDTH-1]}}, min_value};
  end

endmodule

`default_nettype wire

### hdl/twvg_div.sv
// Pipelined restoring divider that produces one quotient bit per stage.
`default_nettype none

module twvg_div #(
  parameter int DVD_WIDTH = 32,
  parameter int DVS_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire logic [DVD_WIDTH-1:0] dividend,
  input  wire logic [DVS_WIDTH-1:0] divisor,
  output logic                      out_valid,
  output logic      [DVD_WIDTH-1:0] quot,
  output logic      [DVS_WIDTH-1:0] rem
);

  logic [DVS_WIDTH-1:0] rem_st [DVD_WIDTH];
  logic [DVD_WIDTH-1:0] dq_st  [DVD_WIDTH];
  logic                 vld_st [DVD_WIDTH];

  for (genvar k = 0; k < DVD_WIDTH; k++) begin : g_stage
    logic [DVS_WIDTH-1:0] rem_in;
    logic [DVD_WIDTH-1:0] dq_in;
    logic                 vld_in;
    logic [DVS_WIDTH:0]   trial;
    logic [DVS_WIDTH:0]   diff;
    logic                 qbit;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_st[k-1];
      assign dq_in  = dq_st[k-1];
      assign vld_in = vld_st[k-1];
    end

    // The dividend register shifts left and takes the quotient bits in at the bottom.
    assign trial = {rem_in, dq_in[DVD_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};
    assign qbit  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_st[k] <= 1'b0;
      end else if (adv) begin
        vld_st[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_st[k] <= qbit ? diff[DVS_WIDTH-1:0] : trial[DVS_WIDTH-1:0];
        dq_st[k]  <= {dq_in[DVD_WIDTH-2:0], qbit};
      end
    end
  end

  assign out_valid = vld_st[DVD_WIDTH-1];
  assign quot      = dq_st[DVD_WIDTH-1];
  assign rem       = rem_st[DVD_WIDTH-1];

  a_rst_empties: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("divider output valid right after reset");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
      !$past(adv) && !$past(rst) |->
        $stable(out_valid) && (!out_valid || ($stable(quot) && $stable(rem))))
    else $error("divider output moved while the pipeline was held");

endmodule

`default_nettype wire

### hdl/triangle_wave_value_generator.sv
// Top level: triangle wave value generator pipeline.
//
// Usage:
//   Input channel (in_valid, in_stall, now_ms) carries one millisecond timestamp
//   per word; output channel (out_valid, out_stall, wave_value) returns exactly
//   one signed wave value per timestamp, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data while no word is
//   in flight: 0 period_ms, 1 phase_ms, 2 min_value, 3 max_value, 4 value_offset.
//   Other indexes are ignored.
// Pipeline: an input register, a TIME_WIDTH stage modulo pipeline, a fold stage,
//   a multiplier stage, a divider pipeline of VALUE_WIDTH + 32 stages, an adder
//   stage and the output register.
// Throughput: one word per cycle while in_stall is low; each divider stage resolves one bit.
// Reset: rst is synchronous; it empties the pipeline and loads period 120000
//   and zero for every other configuration register.
// Stall: the output register holds its word while out_stall is high. The
//   pipeline keeps moving as long as its last stage is empty, so in_stall rises
//   only once a second finished word waits behind the held one.
`default_nettype none

module triangle_wave_value_generator
  import twvg_pkg::*;
#(
  parameter int TIME_WIDTH  = 32,
  parameter int VALUE_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [NOW_WIDTH-1:0]          now_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [VALUE_WIDTH+1:0]      wave_value
);

  localparam int OUT_WIDTH  = VALUE_WIDTH + 2;
  localparam int PROD_WIDTH = VALUE_WIDTH + PERIOD_WIDTH;

  logic [PERIOD_WIDTH-1:0] period;
  logic [NOW_WIDTH-1:0]    phase;
  logic [HALF_WIDTH-1:0]   half;
  logic                    half_zero;
  logic [VALUE_WIDTH-1:0]  span_mag;
  logic                    span_neg;
  logic [OUT_WIDTH-1:0]    base;

  logic                    adv;
  logic                    out_take;
  logic [NOW_WIDTH:0]      sum;

  logic                    t_vld;
  logic [TIME_WIDTH-1:0]   t_val;
  logic                    pos_vld;
  logic [PERIOD_WIDTH-1:0] pos;
  logic                    num_vld;
  logic [PERIOD_WIDTH-1:0] num_val;
  logic                    prod_vld;
  logic [PROD_WIDTH-1:0]   prod_val;
  logic                    quot_vld;
  logic [PROD_WIDTH-1:0]   quot;
  logic [OUT_WIDTH-1:0]    scaled;
  logic                    res_vld;
  logic [OUT_WIDTH-1:0]    res_val;

  twvg_cfg #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .period    (period),
    .phase     (phase),
    .half      (half),
    .half_zero (half_zero),
    .span_mag  (span_mag),
    .span_neg  (span_neg),
    .base      (base)
  );

  // Every stage before the output register moves together; a bubble in the last stage lets the pipeline
  // keep running while the output register is held.
  assign out_take = !out_valid || !out_stall;
  assign adv      = !res_vld || out_take;
  assign in_stall = !adv;

  assign sum = {1'b0, now_ms} + {1'b0, phase};

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld    <= 1'b0;
      num_vld  <= 1'b0;
      prod_vld <= 1'b0;
      res_vld  <= 1'b0;
    end else if (adv) begin
      t_vld    <= in_valid;
      num_vld  <= pos_vld;
      prod_vld <= num_vld;
      res_vld  <= quot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_val    <= TIME_WIDTH'(sum);
      // Past the middle the wave falls back from the peak.
      num_val  <= (pos < {1'b0, half}) ? pos : period - pos;
      prod_val <= PROD_WIDTH'(span_mag) * PROD_WIDTH'(num_val);
      res_val  <= base + scaled;
    end
  end

  twvg_div #(
    .DVD_WIDTH(TIME_WIDTH),
    .DVS_WIDTH(PERIOD_WIDTH)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (t_vld),
    .dividend  (t_val),
    .divisor   (period),
    .out_valid (pos_vld),
    .quot      (),
    .rem       (pos)
  );

  twvg_div #(
    .DVD_WIDTH(PROD_WIDTH),
    .DVS_WIDTH(HALF_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (prod_vld),
    .dividend  (prod_val),
    .divisor   (half),
    .out_valid (quot_vld),
    .quot      (quot),
    .rem       ()
  );

  // A period below two gives a flat wave; the divider result is then meaningless.
  always_comb begin
    if (half_zero) begin
      scaled = '0;
    end else if (span_neg) begin
      scaled = OUT_WIDTH'(0) - quot[OUT_WIDTH-1:0];
    end else begin
      scaled = quot[OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      wave_value <= res_val;
    end
  end

  a_empty_output_never_stalls: assert property (@(posedge clk) disable iff (rst)
      !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  a_last_stage_drains: assert property (@(posedge clk) disable iff (rst)
      res_vld && !in_stall |=> out_valid)
    else $error("finished word left the last stage without reaching the output");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid && $stable(wave_value))
    else $error("output word changed while the receiver stalled");

endmodule

`default_nettype wire

### dv/tb_triangle_wave_value_generator.sv
// Self-checking testbench for the triangle wave value generator.
`timescale 1ns / 100ps

module tb_triangle_wave_value_generator
  import twvg_pkg::*;
();

  localparam int VALUE_W = 24;
  localparam int WAVE_W = VALUE_W + 2;
  localparam int PIPE_LATENCY = 92;
  localparam int NUM_PHASES = 14;
  localparam int PHASE_WORDS = 109;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_LOW = CFG_INDEX_WIDTH'(REG_OFFSET + 1);
  localparam logic [31:0] VAL_MIN = 32'h0080_0000;
  localparam logic [31:0] VAL_MAX = 32'h007F_FFFF;

  typedef struct {
    logic [31:0] period;
    logic [31:0] phase;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] offs;
    logic [31:0] stamp;
    bit typed;
    logic signed [WAVE_W-1:0] want;
  } stim_row_t;

  typedef struct {
    logic [31:0] period;
    logic [31:0] phase;
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    logic signed [VALUE_W-1:0] offs;
  } wave_setting_t;

  typedef struct {
    logic [31:0] stamp;
    logic signed [WAVE_W-1:0] want;
  } wave_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [NOW_WIDTH-1:0] now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WAVE_W-1:0] wave_value;

  wave_setting_t cur;
  wave_expect_t pending_waves[$];
  stim_row_t directed_rows [24];
  int mismatch_count = 0;
  bit steady = 1'b0;

  triangle_wave_value_generator DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .wave_value(wave_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("triangle_wave_value_generator regression: fail");
    $finish;
  end

  // Value the block should produce for one timestamp under the current setting.
  function automatic logic signed [WAVE_W-1:0] wave_at(input logic [31:0] stamp);
    logic [31:0] half_period;
    logic [31:0] shifted;
    logic [31:0] pos;
    logic [31:0] num;
    longint span;
    longint scaled;
    longint total;
    half_period = cur.period / 2;
    span = longint'(cur.hi) - longint'(cur.lo);
    scaled = 0;
    if (half_period != 0) begin
      shifted = stamp + cur.phase;
      pos = shifted % cur.period;
      num = (pos < half_period) ? pos : cur.period - pos;
      scaled = (span * longint'({32'd0, num})) / longint'({32'd0, half_period});
    end
    total = longint'(cur.offs) + longint'(cur.lo) + scaled;
    return total[WAVE_W-1:0];
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(7))
      0: word[VALUE_W-1:0] = VAL_MIN[VALUE_W-1:0];
      1: word[VALUE_W-1:0] = VAL_MAX[VALUE_W-1:0];
      default: ;
    endcase
    return word;
  endfunction

  // The receiver stalls at random except during the steady phase.
  always @(negedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    wave_expect_t head;
    if (!rst && out_valid && !out_stall) begin
      if (pending_waves.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: wave_value %0d", wave_value);
      end else begin
        head = pending_waves.pop_front();
        if (wave_value !== head.want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("wave_value mismatch: now_ms %h expected %0d got %0d",
                     head.stamp, head.want, wave_value);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [31:0] stamp, input bit typed,
                           input logic signed [WAVE_W-1:0] want);
    wave_expect_t entry;
    while (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entry.stamp = stamp;
    entry.want = typed ? want : wave_at(stamp);
    pending_waves.push_back(entry);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_waves.size() != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_PERIOD: cur.period = data;
      REG_PHASE: cur.phase = data;
      REG_MIN: cur.lo = data[VALUE_W-1:0];
      REG_MAX: cur.hi = data[VALUE_W-1:0];
      REG_OFFSET: cur.offs = data[VALUE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] period, input logic [31:0] phase,
                               input logic [31:0] lo, input logic [31:0] hi,
                               input logic [31:0] offs);
    logic [CFG_INDEX_WIDTH-1:0] spare;
    drain();
    spare = CFG_INDEX_WIDTH'($urandom_range((1 << CFG_INDEX_WIDTH) - 1, REG_UNMAPPED_LOW));
    put_reg(spare, $urandom);
    put_reg(REG_PERIOD, period);
    put_reg(REG_PHASE, phase);
    put_reg(REG_MIN, lo);
    put_reg(REG_MAX, hi);
    put_reg(REG_OFFSET, offs);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] last_words [5];
    logic [31:0] period;
    logic [31:0] stamp;
    int quiet_phase;
    directed_rows = '{
      '{PERIOD_RESET, 0, 0, 0, 0, 32'd0, 1, 26'sd0},
      '{PERIOD_RESET, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 26'sd0},
      '{PERIOD_RESET, 0, VAL_MIN, VAL_MAX, 0, 32'd0, 1, -26'sd8388608},
      '{PERIOD_RESET, 0, VAL_MIN, VAL_MAX, 0, 32'd60000, 1, 26'sd8388607},
      '{PERIOD_RESET, 0, VAL_MIN, VAL_MAX, 0, 32'd30000, 0, 26'sd0},
      '{PERIOD_RESET, 0, VAL_MIN, VAL_MAX, 0, 32'd90000, 0, 26'sd0},
      '{PERIOD_RESET, 0, VAL_MIN, VAL_MAX, 0, 32'd119999, 0, 26'sd0},
      '{PERIOD_RESET, 0, VAL_MIN, VAL_MAX, 0, 32'hFFFF_FFFF, 0, 26'sd0},
      '{PERIOD_RESET, 0, VAL_MIN, VAL_MIN, VAL_MIN, 32'd0, 1, -26'sd16777216},
      '{PERIOD_RESET, 0, VAL_MAX, VAL_MAX, VAL_MAX, 32'd12345, 1, 26'sd16777214},
      '{PERIOD_RESET, 0, VAL_MAX, VAL_MIN, VAL_MIN, 32'd60000, 1, -26'sd16777216},
      '{PERIOD_RESET, 0, VAL_MIN, VAL_MAX, VAL_MAX, 32'd60000, 1, 26'sd16777214},
      // A period of zero or one leaves only offset plus minimum.
      '{32'd0, 0, VAL_MIN, VAL_MAX, VAL_MAX, 32'd77, 1, -26'sd1},
      '{32'd1, 0, VAL_MIN, VAL_MAX, VAL_MAX, 32'hDEAD_BEEF, 1, -26'sd1},
      '{32'd2, 0, 32'd100, 32'h00FF_FF9C, 0, 32'd0, 0, 26'sd0},
      '{32'd2, 0, 32'd100, 32'h00FF_FF9C, 0, 32'd1, 0, 26'sd0},
      // With an odd period the falling side starts one step above the peak.
      '{32'd3, 0, 32'd100, 32'h00FF_FF9C, 0, 32'd1, 0, 26'sd0},
      '{32'd3, 0, 32'd100, 32'h00FF_FF9C, 0, 32'd2, 0, 26'sd0},
      // The timestamp plus phase wraps around the 32-bit range, then the period takes its largest value.
      '{PERIOD_RESET, 32'hFFFF_FFFF, VAL_MIN, VAL_MAX, 0, 32'd1, 1, -26'sd8388608},
      '{PERIOD_RESET, 32'h8000_0000, VAL_MIN, VAL_MAX, 0, 32'h8000_0005, 0, 26'sd0},
      '{32'hFFFF_FFFF, 0, VAL_MIN, VAL_MAX, 0, 32'hFFFF_FFFE, 0, 26'sd0},
      '{32'hFFFF_FFFF, 0, VAL_MIN, VAL_MAX, 0, 32'h7FFF_FFFF, 0, 26'sd0},
      // Negative span with a remainder: the quotient truncates toward zero.
      '{32'd7, 0, 32'd0, 32'h00FF_FFFB, 32'd5, 32'd2, 0, 26'sd0},
      '{32'd7, 0, 32'd0, 32'h00FF_FFFB, 32'd5, 32'd5, 0, 26'sd0}
    };
    cur.period = PERIOD_RESET;
    cur.phase = '0;
    cur.lo = '0;
    cur.hi = '0;
    cur.offs = '0;
    last_words = '{PERIOD_RESET, 32'd0, 32'd0, 32'd0, 32'd0};
    quiet_phase = $urandom_range(NUM_PHASES - 1);

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].period != last_words[0] || directed_rows[i].phase != last_words[1] ||
          directed_rows[i].lo != last_words[2] || directed_rows[i].hi != last_words[3] ||
          directed_rows[i].offs != last_words[4]) begin
        apply_setting(directed_rows[i].period, directed_rows[i].phase, directed_rows[i].lo,
                      directed_rows[i].hi, directed_rows[i].offs);
        last_words = '{directed_rows[i].period, directed_rows[i].phase, directed_rows[i].lo,
                       directed_rows[i].hi, directed_rows[i].offs};
      end
      send_word(directed_rows[i].stamp, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(7))
        0: period = $urandom_range(1);
        1: period = $urandom_range(9, 2);
        2: period = $urandom_range(1000, 2);
        3: period = $urandom_range(1 << 16);
        4: period = $urandom;
        5: period = 32'hFFFF_FFFF;
        6: period = PERIOD_RESET;
        default: period = $urandom_range(64, 2);
      endcase
      apply_setting(period, ($urandom_range(1) != 0) ? $urandom : 32'd0,
                    pick_value(), pick_value(), pick_value());
      steady = (p == quiet_phase);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Once, hold the sender back until the pipeline has emptied.
        if (p == 2 && n == PHASE_WORDS / 2) drain();
        case ($urandom_range(7))
          0: stamp = 32'hFFFF_FFFF - $urandom_range(20);
          1: stamp = $urandom_range(300);
          default: stamp = $urandom;
        endcase
        send_word(stamp, 1'b0, '0);
      end
      steady = 1'b0;
    end

    drain();
    repeat (PIPE_LATENCY + 20) @(negedge clk);
    mismatch_count += pending_waves.size();
    if (mismatch_count == 0) begin
      $display("triangle_wave_value_generator regression: pass");
    end else begin
      $display("triangle_wave_value_generator regression: fail");
    end
    $finish;
  end

endmodule
